>>> hdl/ltrc_pkg.sv
package ltrc_pkg;

  localparam int unsigned LevelW = 12;
  localparam int unsigned BandW  = 10;
  localparam int unsigned CountW = 8;
  localparam int unsigned RunW   = 16;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned ModeW  = 2;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 12;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TRIP_LEVEL   = 3'd0,
    CFG_DARK_LEVEL   = 3'd1,
    CFG_COMPARE_MODE = 3'd2,
    CFG_RELAY_ASSIGN = 3'd3,
    CFG_HYST_BAND    = 3'd4,
    CFG_CONSEC_NEED  = 3'd5,
    CFG_ERROR_LIMIT  = 3'd6,
    CFG_UNUSED       = 3'd7
  } cfg_idx_e;

  typedef enum logic [ModeW-1:0] {
    MODE_NONE  = 2'd0,
    MODE_BELOW = 2'd1,
    MODE_ABOVE = 2'd2,
    MODE_SPARE = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_ON    = 2'd1,
    CMD_OFF   = 2'd2,
    CMD_SPARE = 2'd3
  } relay_cmd_e;

  typedef struct packed {
    logic [LevelW-1:0] trip_level;
    logic [LevelW-1:0] dark_level;
    mode_e             compare_mode;
    logic              relay_assigned;
    logic [BandW-1:0]  hysteresis_band;
    logic [CountW-1:0] consecutive_needed;
    logic [CountW-1:0] error_limit;
  } cfg_t;

  // Classified poll handed from the front to the back.
  typedef struct packed {
    logic             read_ok;
    logic             is_light;
    logic             want_on;
    logic             want_off;
    logic [TimeW-1:0] now_seconds;
  } cls_t;

  typedef struct packed {
    logic             sample_ok;
    logic             display_ok;
    relay_cmd_e       relay_command;
    logic             light_started;
    logic             light_stopped;
    logic [TimeW-1:0] light_seconds;
  } result_t;

endpackage

>>> hdl/light_threshold_relay_control.sv
// Light threshold relay control. Each transaction on the input queue is one
// photo-sensor poll (read flag, 12-bit converter value, current seconds) and
// yields exactly one result transaction on the output queue: the read flag,
// a display-ok flag, a relay command (none, on, off), light-period start and
// stop strobes and the light-period length in seconds. The block sustains one
// poll per clock cycle while the result queue has room or is popped; each poll
// is queued in the front queue, its result in the result queue, and results
// leave in the order the polls arrived. The front classifies each poll against
// the trip, hysteresis and dark levels and places it in a two-entry queue; the
// back applies it to the run counters and timing state, which is the one
// dependent step per poll, and writes a two-entry result queue. Either side may
// stall without holding up the other until its queue is full. Configuration
// writes are always ready and take effect on the next cycle; they should only
// be made while no poll is in flight.
module light_threshold_relay_control
  import ltrc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration write channel.
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // Poll input queue.
  input  logic                push,
  output logic                full,
  input  logic                read_ok_i,
  input  logic [LevelW-1:0]   sample_value_i,
  input  logic [TimeW-1:0]    now_seconds_i,
  // Result output queue.
  output logic                empty,
  input  logic                pop,
  output logic                sample_ok_o,
  output logic                display_ok_o,
  output logic [1:0]          relay_command_o,
  output logic                light_started_o,
  output logic                light_stopped_o,
  output logic [TimeW-1:0]    light_seconds_o
);

  cfg_t    cfg_q;
  logic    mid_empty;
  logic    mid_pop;
  cls_t    mid_head;
  result_t res_head;

  // The register file accepts a write on every cycle. Writes to the unused
  // index are accepted and discarded.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.trip_level         <= LevelW'(2048);
      cfg_q.dark_level         <= '0;
      cfg_q.compare_mode       <= MODE_NONE;
      cfg_q.relay_assigned     <= 1'b0;
      cfg_q.hysteresis_band    <= BandW'(50);
      cfg_q.consecutive_needed <= CountW'(5);
      cfg_q.error_limit        <= CountW'(5);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_TRIP_LEVEL:   cfg_q.trip_level         <= cfg_data_i[LevelW-1:0];
        CFG_DARK_LEVEL:   cfg_q.dark_level         <= cfg_data_i[LevelW-1:0];
        CFG_COMPARE_MODE: cfg_q.compare_mode       <= mode_e'(cfg_data_i[ModeW-1:0]);
        CFG_RELAY_ASSIGN: cfg_q.relay_assigned     <= cfg_data_i[0];
        CFG_HYST_BAND:    cfg_q.hysteresis_band    <= cfg_data_i[BandW-1:0];
        CFG_CONSEC_NEED:  cfg_q.consecutive_needed <= cfg_data_i[CountW-1:0];
        CFG_ERROR_LIMIT:  cfg_q.error_limit        <= cfg_data_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  // Front: classification of each poll and the queue towards the back.
  ltrc_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .push_i         (push),
    .full_o         (full),
    .read_ok_i      (read_ok_i),
    .sample_value_i (sample_value_i),
    .now_seconds_i  (now_seconds_i),
    .pop_i          (mid_pop),
    .empty_o        (mid_empty),
    .head_o         (mid_head)
  );

  // Back: run counters, arming, period timing and the result queue.
  ltrc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_empty_i (mid_empty),
    .in_head_i  (mid_head),
    .in_pop_o   (mid_pop),
    .pop_i      (pop),
    .empty_o    (empty),
    .head_o     (res_head)
  );

  assign sample_ok_o     = res_head.sample_ok;
  assign display_ok_o    = res_head.display_ok;
  assign relay_command_o = res_head.relay_command;
  assign light_started_o = res_head.light_started;
  assign light_stopped_o = res_head.light_stopped;
  assign light_seconds_o = res_head.light_seconds;

endmodule

>>> hdl/ltrc_front.sv
module ltrc_front
  import ltrc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              push_i,
  output logic              full_o,
  input  logic              read_ok_i,
  input  logic [LevelW-1:0] sample_value_i,
  input  logic [TimeW-1:0]  now_seconds_i,
  input  logic              pop_i,
  output logic              empty_o,
  output cls_t              head_o
);

  cls_t       entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_push, do_pop;
  cls_t       cls;

  logic [LevelW:0] sum_trip_band;
  logic [LevelW:0] sum_val_band;
  logic            below_trip, above_trip;

  // The hysteresis thresholds are compared with one extra bit so that
  // trip minus band never wraps: v <= trip - band is v + band <= trip.
  always_comb begin
    sum_trip_band = {1'b0, cfg_i.trip_level} + {{(LevelW+1-BandW){1'b0}}, cfg_i.hysteresis_band};
    sum_val_band  = {1'b0, sample_value_i} + {{(LevelW+1-BandW){1'b0}}, cfg_i.hysteresis_band};
    below_trip    = sample_value_i < cfg_i.trip_level;
    above_trip    = sample_value_i > cfg_i.trip_level;

    cls             = '0;
    cls.read_ok     = read_ok_i;
    cls.is_light    = sample_value_i >= cfg_i.dark_level;
    cls.now_seconds = now_seconds_i;
    unique case (cfg_i.compare_mode)
      MODE_BELOW: begin
        cls.want_on  = below_trip;
        cls.want_off = {1'b0, sample_value_i} >= sum_trip_band;
      end
      MODE_ABOVE: begin
        cls.want_on  = above_trip;
        cls.want_off = sum_val_band <= {1'b0, cfg_i.trip_level};
      end
      default: begin
        cls.want_on  = 1'b0;
        cls.want_off = 1'b0;
      end
    endcase
  end

  assign full_o  = count_q == 2'd2;
  assign empty_o = count_q == 2'd0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= cls;
    end
  end

endmodule

>>> hdl/ltrc_back.sv
module ltrc_back
  import ltrc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    in_empty_i,
  input  cls_t    in_head_i,
  output logic    in_pop_o,
  input  logic    pop_i,
  output logic    empty_o,
  output result_t head_o
);

  logic [RunW-1:0]   on_run_q, on_run_d;
  logic [RunW-1:0]   off_run_q, off_run_d;
  logic [RunW-1:0]   light_run_q, light_run_d;
  logic [RunW-1:0]   dark_run_q, dark_run_d;
  logic              start_armed_q, start_armed_d;
  logic              stop_armed_q, stop_armed_d;
  logic [TimeW-1:0]  period_start_q, period_start_d;
  logic [TimeW-1:0]  period_length_q, period_length_d;
  logic [CountW-1:0] error_run_q, error_run_d;
  mode_e             last_mode_q, last_mode_d;

  result_t    entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       out_pop, out_room, step;
  result_t    res;

  logic [RunW-1:0] need;
  logic [RunW-1:0] on_base, off_base;

  assign out_pop  = pop_i && !empty_o;
  assign out_room = (count_q != 2'd2) || out_pop;
  assign step     = !in_empty_i && out_room;
  assign in_pop_o = step;
  assign empty_o  = count_q == 2'd0;
  assign head_o   = entry_q[rd_ptr_q];
  assign need     = {{(RunW-CountW){1'b0}}, cfg_i.consecutive_needed};

  always_comb begin
    on_run_d        = on_run_q;
    off_run_d       = off_run_q;
    light_run_d     = light_run_q;
    dark_run_d      = dark_run_q;
    start_armed_d   = start_armed_q;
    stop_armed_d    = stop_armed_q;
    period_start_d  = period_start_q;
    period_length_d = period_length_q;
    error_run_d     = error_run_q;
    last_mode_d     = last_mode_q;
    on_base         = on_run_q;
    off_base        = off_run_q;
    res             = '0;
    res.relay_command = CMD_NONE;

    if (!in_head_i.read_ok) begin
      if (error_run_q != {CountW{1'b1}}) begin
        error_run_d = error_run_q + 1'b1;
      end
    end else begin
      error_run_d = '0;

      // A change of compare mode restarts both relay runs.
      if (cfg_i.compare_mode != last_mode_q) begin
        on_base     = '0;
        off_base    = '0;
        last_mode_d = cfg_i.compare_mode;
      end
      on_run_d  = on_base;
      off_run_d = off_base;

      if (in_head_i.is_light) begin
        dark_run_d = '0;
        if (light_run_q != {RunW{1'b1}}) begin
          light_run_d = light_run_q + 1'b1;
        end
        if (light_run_d >= need) begin
          stop_armed_d = 1'b1;
          if (start_armed_q) begin
            start_armed_d     = 1'b0;
            period_length_d   = '0;
            period_start_d    = in_head_i.now_seconds;
            res.light_started = 1'b1;
          end else begin
            period_length_d = in_head_i.now_seconds - period_start_q;
          end
        end
      end else begin
        light_run_d = '0;
        if (dark_run_q != {RunW{1'b1}}) begin
          dark_run_d = dark_run_q + 1'b1;
        end
        if (dark_run_d >= need) begin
          start_armed_d = 1'b1;
          if (stop_armed_q) begin
            stop_armed_d      = 1'b0;
            res.light_stopped = 1'b1;
          end
        end
      end

      if (in_head_i.want_on) begin
        off_run_d = '0;
        if (on_base != {RunW{1'b1}}) begin
          on_run_d = on_base + 1'b1;
        end
        if (cfg_i.relay_assigned && on_run_d >= need) begin
          res.relay_command = CMD_ON;
        end
      end else if (in_head_i.want_off) begin
        on_run_d = '0;
        if (off_base != {RunW{1'b1}}) begin
          off_run_d = off_base + 1'b1;
        end
        if (cfg_i.relay_assigned && off_run_d >= need) begin
          res.relay_command = CMD_OFF;
        end
      end
    end

    res.sample_ok     = in_head_i.read_ok;
    res.display_ok    = error_run_d < cfg_i.error_limit;
    res.light_seconds = period_length_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_run_q        <= '0;
      off_run_q       <= '0;
      light_run_q     <= '0;
      dark_run_q      <= '0;
      start_armed_q   <= 1'b1;
      stop_armed_q    <= 1'b1;
      period_start_q  <= '0;
      period_length_q <= '0;
      error_run_q     <= '0;
      last_mode_q     <= MODE_NONE;
      wr_ptr_q        <= 1'b0;
      rd_ptr_q        <= 1'b0;
      count_q         <= 2'd0;
    end else begin
      if (step) begin
        on_run_q        <= on_run_d;
        off_run_q       <= off_run_d;
        light_run_q     <= light_run_d;
        dark_run_q      <= dark_run_d;
        start_armed_q   <= start_armed_d;
        stop_armed_q    <= stop_armed_d;
        period_start_q  <= period_start_d;
        period_length_q <= period_length_d;
        error_run_q     <= error_run_d;
        last_mode_q     <= last_mode_d;
        wr_ptr_q        <= ~wr_ptr_q;
      end
      if (out_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_q + {1'b0, step} - {1'b0, out_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      entry_q[wr_ptr_q] <= res;
    end
  end

endmodule

>>> dv/ltrc_scoreboard_pkg.sv
`timescale 1ns / 1ps

package ltrc_scoreboard_pkg;
  import ltrc_pkg::*;

  // One sensor poll as the testbench hands it over.
  typedef struct packed {
    logic              read_ok;
    logic [LevelW-1:0] sample_value;
    logic [TimeW-1:0]  now_seconds;
  } poll_t;

  class relay_scoreboard;
    int unsigned failures = 0;
    int unsigned result_no = 0;

    // Mirror of the register file and of the relay and light-timing state.
    cfg_t             cfg;
    logic [RunW-1:0]   on_cnt, off_cnt, lit_cnt, dim_cnt;
    bit                arm_start, arm_stop;
    logic [TimeW-1:0]  t_begin, t_len;
    logic [CountW-1:0] fail_cnt;
    mode_e             prev_mode;

    result_t awaited_results[$];

    function void reset_state();
      cfg.trip_level         = 12'd2048;
      cfg.dark_level         = '0;
      cfg.compare_mode       = MODE_NONE;
      cfg.relay_assigned     = 1'b0;
      cfg.hysteresis_band    = 10'd50;
      cfg.consecutive_needed = 8'd5;
      cfg.error_limit        = 8'd5;
      on_cnt    = '0;
      off_cnt   = '0;
      lit_cnt   = '0;
      dim_cnt   = '0;
      arm_start = 1'b1;
      arm_stop  = 1'b1;
      t_begin   = '0;
      t_len     = '0;
      fail_cnt  = '0;
      prev_mode = MODE_NONE;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CfgDataW-1:0] data);
      case (idx)
        CFG_TRIP_LEVEL:   cfg.trip_level         = data[LevelW-1:0];
        CFG_DARK_LEVEL:   cfg.dark_level         = data[LevelW-1:0];
        CFG_COMPARE_MODE: cfg.compare_mode       = mode_e'(data[ModeW-1:0]);
        CFG_RELAY_ASSIGN: cfg.relay_assigned     = data[0];
        CFG_HYST_BAND:    cfg.hysteresis_band    = data[BandW-1:0];
        CFG_CONSEC_NEED:  cfg.consecutive_needed = data[CountW-1:0];
        CFG_ERROR_LIMIT:  cfg.error_limit        = data[CountW-1:0];
        default: ;
      endcase
    endfunction

    function logic [RunW-1:0] bump(logic [RunW-1:0] x);
      return (x == '1) ? x : x + 1'b1;
    endfunction

    // Works out the result of one poll and advances the mirrored state.
    function result_t predict(poll_t p);
      result_t r;
      int v, trip, band;
      bit want_on, want_off;
      r = '0;
      r.relay_command = CMD_NONE;
      v    = p.sample_value;
      trip = cfg.trip_level;
      band = cfg.hysteresis_band;
      if (!p.read_ok) begin
        if (fail_cnt != '1) fail_cnt = fail_cnt + 1'b1;
      end else begin
        fail_cnt = '0;
        if (cfg.compare_mode != prev_mode) begin
          on_cnt    = '0;
          off_cnt   = '0;
          prev_mode = cfg.compare_mode;
        end
        if (v >= int'(cfg.dark_level)) begin
          lit_cnt = bump(lit_cnt);
          dim_cnt = '0;
          if (lit_cnt >= cfg.consecutive_needed) begin
            arm_stop = 1'b1;
            if (arm_start) begin
              arm_start       = 1'b0;
              t_len           = '0;
              t_begin         = p.now_seconds;
              r.light_started = 1'b1;
            end else begin
              t_len = p.now_seconds - t_begin;
            end
          end
        end else begin
          lit_cnt = '0;
          dim_cnt = bump(dim_cnt);
          if (dim_cnt >= cfg.consecutive_needed) begin
            arm_start = 1'b1;
            if (arm_stop) begin
              arm_stop        = 1'b0;
              r.light_stopped = 1'b1;
            end
          end
        end
        if (cfg.compare_mode == MODE_BELOW || cfg.compare_mode == MODE_ABOVE) begin
          if (cfg.compare_mode == MODE_BELOW) begin
            want_on  = v < trip;
            want_off = v >= trip + band;
          end else begin
            want_on  = v > trip;
            want_off = v <= trip - band;
          end
          if (want_on) begin
            on_cnt  = bump(on_cnt);
            off_cnt = '0;
            if (cfg.relay_assigned && on_cnt >= cfg.consecutive_needed)
              r.relay_command = CMD_ON;
          end else if (want_off) begin
            on_cnt  = '0;
            off_cnt = bump(off_cnt);
            if (cfg.relay_assigned && off_cnt >= cfg.consecutive_needed)
              r.relay_command = CMD_OFF;
          end
        end
      end
      r.sample_ok     = p.read_ok;
      r.display_ok    = (fail_cnt < cfg.error_limit);
      r.light_seconds = t_len;
      return r;
    endfunction

    function void note_poll(poll_t p);
      awaited_results.push_back(predict(p));
    endfunction

    function int outstanding();
      return awaited_results.size();
    endfunction

    function void report_mismatch(string msg);
      failures++;
      $display("MISMATCH: %s", msg);
    endfunction

    function void compare_field(string field, longint unsigned got, longint unsigned exp);
      if (got != exp)
        report_mismatch($sformatf("result %0d %s got %0d expected %0d",
                                  result_no, field, got, exp));
    endfunction

    function void check_result(result_t got);
      result_t exp;
      if (awaited_results.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with no poll outstanding", result_no));
      end else begin
        exp = awaited_results.pop_front();
        compare_field("sample_ok", got.sample_ok, exp.sample_ok);
        compare_field("display_ok", got.display_ok, exp.display_ok);
        compare_field("relay_command", got.relay_command, exp.relay_command);
        compare_field("light_started", got.light_started, exp.light_started);
        compare_field("light_stopped", got.light_stopped, exp.light_stopped);
        compare_field("light_seconds", got.light_seconds, exp.light_seconds);
      end
      result_no++;
    endfunction
  endclass

endpackage

>>> dv/light_threshold_relay_control_test.sv
`timescale 1ns / 1ps

// Self-checking bench for the light threshold relay control. Polls are pushed
// into the input queue and results are popped from the output queue, each side
// with its own random idle pattern. Every accepted poll is handed to the
// scoreboard, which predicts its result; every popped result is checked
// against the oldest prediction. The run walks through a short directed
// sequence and then a series of configuration phases, the register extremes
// among them, with stimulus built from runs of similar samples so that the
// debounce counters actually reach their thresholds.
module light_threshold_relay_control_test;
  import ltrc_pkg::*;
  import ltrc_scoreboard_pkg::*;

  localparam int TIMEOUT_NS = 5_000_000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                push = 1'b0;
  logic                full;
  logic                read_ok_i = 1'b0;
  logic [LevelW-1:0]   sample_value_i = '0;
  logic [TimeW-1:0]    now_seconds_i = '0;
  logic                empty;
  logic                pop = 1'b0;
  logic                sample_ok_o;
  logic                display_ok_o;
  logic [1:0]          relay_command_o;
  logic                light_started_o;
  logic                light_stopped_o;
  logic [TimeW-1:0]    light_seconds_o;

  light_threshold_relay_control DUT (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i,
    .push,
    .full,
    .read_ok_i,
    .sample_value_i,
    .now_seconds_i,
    .empty,
    .pop,
    .sample_ok_o,
    .display_ok_o,
    .relay_command_o,
    .light_started_o,
    .light_stopped_o,
    .light_seconds_o
  );

  always #6 clk_i = ~clk_i;

  relay_scoreboard sb;

  // Current settings, kept here so that the stimulus can aim at the thresholds.
  int cur_trip, cur_dark, cur_band, cur_need, cur_limit;
  // Idle style of each side: 0 never idles, 1 draws a random idle gap before every item, 2 idles now and then.
  int send_style = 0;
  int recv_style = 0;
  logic [TimeW-1:0] clock_now;

  function automatic int draw_gap(int style);
    case (style)
      0: return 0;
      1: return $urandom_range(0, 6);
      default: return ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 6)) : 0;
    endcase
  endfunction

  // Picks a sensor value, most often right at one of the decision edges: the trip
  // level, either side of the hysteresis band, the dark level, or the range limits.
  function automatic logic [LevelW-1:0] pick_level();
    int x;
    case ($urandom_range(0, 11))
      0: x = cur_trip;
      1: x = cur_trip - 1;
      2: x = cur_trip + 1;
      3: x = cur_trip + cur_band;
      4: x = cur_trip + cur_band - 1;
      5: x = cur_trip - cur_band;
      6: x = cur_trip - cur_band + 1;
      7: x = cur_dark;
      8: x = cur_dark - 1;
      9: x = 0;
      10: x = 4095;
      default: x = $urandom_range(0, 4095);
    endcase
    if (x < 0) x = 0;
    if (x > 4095) x = 4095;
    return x[LevelW-1:0];
  endfunction

  // Register data carries random bits above the register's own width, which the
  // block must ignore.
  function automatic logic [CfgDataW-1:0] with_noise(int value, int bits);
    logic [CfgDataW-1:0] mask;
    mask = (CfgDataW'(1) << bits) - 1'b1;
    return (CfgDataW'($urandom) & ~mask) | (CfgDataW'(value) & mask);
  endfunction

  // Offers one poll and holds it until the block takes it. Push is left high
  // afterwards; the next call or the settling task decides whether it drops.
  task automatic send_poll(input logic ok, input logic [LevelW-1:0] level);
    int gap;
    poll_t p;
    gap = draw_gap(send_style);
    @(negedge clk_i);
    if (gap > 0) begin
      push = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push           = 1'b1;
    read_ok_i      = ok;
    sample_value_i = level;
    now_seconds_i  = clock_now;
    do @(posedge clk_i); while (full);
    p.read_ok      = ok;
    p.sample_value = level;
    p.now_seconds  = clock_now;
    sb.note_poll(p);
    // Time mostly creeps forward, sometimes stands still, and now and then jumps.
    if ($urandom_range(0, 19) == 0) clock_now = $urandom;
    else clock_now = clock_now + $urandom_range(0, 5);
  endtask

  // Stops pushing and waits until every outstanding result has been popped and
  // the pipeline has had time to drain.
  task automatic settle();
    @(negedge clk_i);
    push = 1'b0;
    while (sb.outstanding() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, data);
  endtask

  // Writes the whole register file while the block is idle, then picks new idle
  // styles for both sides.
  task automatic configure(input int trip, input int dark, input int mode, input int relay,
                           input int band, input int need, input int limit);
    settle();
    write_reg(CFG_TRIP_LEVEL, with_noise(trip, LevelW));
    write_reg(CFG_DARK_LEVEL, with_noise(dark, LevelW));
    write_reg(CFG_COMPARE_MODE, with_noise(mode, ModeW));
    write_reg(CFG_RELAY_ASSIGN, with_noise(relay, 1));
    write_reg(CFG_HYST_BAND, with_noise(band, BandW));
    write_reg(CFG_CONSEC_NEED, with_noise(need, CountW));
    write_reg(CFG_ERROR_LIMIT, with_noise(limit, CountW));
    write_reg(CFG_UNUSED, CfgDataW'($urandom));
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
    cur_trip   = trip;
    cur_dark   = dark;
    cur_band   = band;
    cur_need   = need;
    cur_limit  = limit;
    send_style = $urandom_range(0, 2);
    recv_style = $urandom_range(0, 2);
  endtask

  // Sends polls in runs of one level, each 1 to min(need + 3, 20) polls long,
  // with occasional stray samples and stray failed reads. Some runs are strings
  // of 1 to min(limit + 2, 20) failed reads, which may cross the error limit.
  task automatic run_segments(input int count);
    int sent, len, seg_max, i;
    logic [LevelW-1:0] base;
    bit fail_run;
    sent    = 0;
    seg_max = (cur_need + 3 > 20) ? 20 : cur_need + 3;
    while (sent < count) begin
      fail_run = ($urandom_range(0, 7) == 0);
      base     = pick_level();
      len      = fail_run ? $urandom_range(1, (cur_limit + 2 > 20) ? 20 : cur_limit + 2)
                          : $urandom_range(1, seg_max);
      for (i = 0; i < len; i++) begin
        if (fail_run) send_poll(1'b0, LevelW'($urandom));
        else if ($urandom_range(0, 15) == 0) send_poll(1'b0, pick_level());
        else if ($urandom_range(0, 5) == 0) send_poll(1'b1, pick_level());
        else send_poll(1'b1, base);
      end
      sent += len;
    end
  endtask

  // The receiving side pops whenever a result is waiting, after its own idle gap.
  initial begin : result_drain
    int gap;
    result_t got;
    wait (rst_ni === 1'b1);
    forever begin
      gap = draw_gap(recv_style);
      @(negedge clk_i);
      if (gap > 0) begin
        pop = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      pop = 1'b1;
      do @(posedge clk_i); while (empty);
      got.sample_ok     = sample_ok_o;
      got.display_ok    = display_ok_o;
      got.relay_command = relay_cmd_e'(relay_command_o);
      got.light_started = light_started_o;
      got.light_stopped = light_stopped_o;
      got.light_seconds = light_seconds_o;
      sb.check_result(got);
    end
  end

  initial begin : stimulus
    int p, n, waited;
    sb = new;
    sb.reset_state();
    clock_now = $urandom;
    cur_trip  = 2048;
    cur_dark  = 0;
    cur_band  = 50;
    cur_need  = 5;
    cur_limit = 5;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part. With the reset settings every sample counts as light and
    // no relay mode is selected.
    send_poll(1'b1, 12'd0);
    send_poll(1'b0, 12'd4095);

    // Below-trip mode with a short debounce: the error limit is crossed, the
    // on command fires with the first qualified dark period, a value just
    // inside the band leaves the runs alone, and the period timer wraps.
    configure(2048, 1000, MODE_BELOW, 1, 50, 2, 2);
    send_poll(1'b0, 12'd0);
    send_poll(1'b0, 12'd0);
    send_poll(1'b0, 12'd0);
    send_poll(1'b1, 12'd0);
    send_poll(1'b1, 12'd0);
    send_poll(1'b1, 12'd2097);
    send_poll(1'b1, 12'd2098);
    clock_now = 32'hFFFF_FFFE;
    send_poll(1'b1, 12'd4095);
    send_poll(1'b1, 12'd4095);
    send_poll(1'b1, 12'd2047);
    send_poll(1'b1, 12'd1000);
    send_poll(1'b1, 12'd999);

    // Above-trip mode: the mode change clears the runs, and the off threshold
    // sits exactly at the trip level less the band.
    configure(2048, 4095, MODE_ABOVE, 1, 50, 1, 1);
    send_poll(1'b1, 12'd2049);
    send_poll(1'b1, 12'd2048);
    send_poll(1'b1, 12'd1998);
    send_poll(1'b1, 12'd4095);
    send_poll(1'b0, 12'd0);

    // The spare mode behaves like no mode; a zero debounce count qualifies every
    // sample and a zero error limit keeps the display flag low.
    configure(2048, 2048, MODE_SPARE, 1, 50, 0, 0);
    send_poll(1'b1, 12'd0);
    send_poll(1'b1, 12'd4095);

    // Phases at the register extremes.
    configure(2048, 1024, MODE_BELOW, 1, 50, 3, 3);
    run_segments(80);
    configure(0, 4095, MODE_ABOVE, 1, 1023, 1, 1);
    run_segments(60);
    configure(4095, 0, MODE_BELOW, 1, 0, 0, 0);
    run_segments(60);
    configure(1500, 2500, MODE_SPARE, 1, 20, 2, 2);
    run_segments(40);
    configure(3000, 500, MODE_NONE, 1, 100, 2, 4);
    run_segments(30);

    // Largest debounce count and error limit, with a long string of failed reads
    // that drives the error count into saturation.
    configure(2048, 2048, MODE_ABOVE, 0, 300, 255, 255);
    for (n = 0; n < 260; n++) send_poll(1'b0, LevelW'($urandom));
    send_poll(1'b1, 12'd4095);
    run_segments(40);

    // Random settings, biased towards the two relay modes and short counts.
    for (p = 0; p < 8; p++) begin
      configure(($urandom_range(0, 4) == 0) ? (($urandom_range(0, 1) != 0) ? 0 : 4095)
                                            : int'($urandom_range(0, 4095)),
                ($urandom_range(0, 4) == 0) ? (($urandom_range(0, 1) != 0) ? 0 : 4095)
                                            : int'($urandom_range(0, 4095)),
                ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, 3))
                                            : int'($urandom_range(1, 2)),
                ($urandom_range(0, 3) != 0) ? 1 : 0,
                ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, 1023))
                                            : int'($urandom_range(0, 100)),
                $urandom_range(0, 6),
                $urandom_range(0, 6));
      run_segments($urandom_range(20, 45));
    end

    // Drain what is left, then allow a few more cycles for stray results.
    @(negedge clk_i);
    push = 1'b0;
    waited = 0;
    while (sb.outstanding() != 0 && waited < 5000) begin
      @(negedge clk_i);
      waited++;
    end
    if (sb.outstanding() != 0)
      sb.report_mismatch($sformatf("%0d results never arrived", sb.outstanding()));
    repeat (8) @(negedge clk_i);
    if (sb.failures == 0) begin
      $display("** light_threshold_relay_control: PASSED **");
    end else begin
      $display("** light_threshold_relay_control: FAILED **");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("Timeout after %0d ns", TIMEOUT_NS);
    $display("** light_threshold_relay_control: FAILED **");
    $finish;
  end

endmodule

>>> files.f
hdl/ltrc_pkg.sv
hdl/ltrc_front.sv
hdl/ltrc_back.sv
hdl/light_threshold_relay_control.sv
dv/ltrc_scoreboard_pkg.sv
dv/light_threshold_relay_control_test.sv
